@@ hdl/ldadsr_pkg.sv @@
// ----------------------------------------------------------------------------
// ldadsr_pkg - shared types and constants of the linear DADSR envelope
// Register map, stage codes, sequencer states and the structs passed
// between the register file, the sequencer and the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ldadsr_pkg;

  // Default values for the top-level parameters
  localparam int FRAC_BITS_DEF  = 23;
  localparam int COUNT_BITS_DEF = 24;

  // Fixed field widths
  localparam int CFG_W  = 24;   // stage lengths and sustain level
  localparam int GAIN_W = 16;
  localparam int OUT_W  = 16;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'h8000;

  typedef enum logic [2:0] {
    REG_DELAY   = 3'd0,
    REG_ATTACK  = 3'd1,
    REG_DECAY   = 3'd2,
    REG_RELEASE = 3'd3,
    REG_SUSTAIN = 3'd4,
    REG_GAIN    = 3'd5,
    REG_LOOP    = 3'd6
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_OFF     = 3'd0,
    ST_DELAY   = 3'd1,
    ST_ATTACK  = 3'd2,
    ST_DECAY   = 3'd3,
    ST_SUSTAIN = 3'd4,
    ST_RELEASE = 3'd5
  } stage_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_MUL,
    S_DONE
  } seq_state_t;

  typedef struct packed {
    logic [CFG_W-1:0]  delay_samples;
    logic [CFG_W-1:0]  attack_samples;
    logic [CFG_W-1:0]  decay_samples;
    logic [CFG_W-1:0]  release_samples;
    logic [CFG_W-1:0]  sustain_level;
    logic [GAIN_W-1:0] output_gain;
    logic              loop_enable;
  } cfg_t;

  typedef struct packed {
    logic [OUT_W-1:0] envelope;
    stage_t           stage;
  } res_t;

endpackage

`default_nettype wire

@@ hdl/ldadsr_regs.sv @@
// ----------------------------------------------------------------------------
// ldadsr_regs - configuration register file
// APB-style write and read of the seven envelope settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ldadsr_regs (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [ldadsr_pkg::ADDR_W-1:0] paddr,
  input  wire logic [ldadsr_pkg::DATA_W-1:0] pwdata,
  output logic      [ldadsr_pkg::DATA_W-1:0] prdata,
  output logic                               pready,
  output ldadsr_pkg::cfg_t                   cfg
);

  ldadsr_pkg::cfg_t cfg_r;
  logic [2:0]       idx;
  logic             wr_en;

  assign idx    = paddr[ldadsr_pkg::ADDR_W-1:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.delay_samples   <= '0;
      cfg_r.attack_samples  <= '0;
      cfg_r.decay_samples   <= '0;
      cfg_r.release_samples <= '0;
      cfg_r.sustain_level   <= '0;
      cfg_r.output_gain     <= ldadsr_pkg::GAIN_RESET;
      cfg_r.loop_enable     <= 1'b0;
    end else if (wr_en) begin
      case (idx)
        ldadsr_pkg::REG_DELAY:   cfg_r.delay_samples   <= pwdata[ldadsr_pkg::CFG_W-1:0];
        ldadsr_pkg::REG_ATTACK:  cfg_r.attack_samples  <= pwdata[ldadsr_pkg::CFG_W-1:0];
        ldadsr_pkg::REG_DECAY:   cfg_r.decay_samples   <= pwdata[ldadsr_pkg::CFG_W-1:0];
        ldadsr_pkg::REG_RELEASE: cfg_r.release_samples <= pwdata[ldadsr_pkg::CFG_W-1:0];
        ldadsr_pkg::REG_SUSTAIN: cfg_r.sustain_level   <= pwdata[ldadsr_pkg::CFG_W-1:0];
        ldadsr_pkg::REG_GAIN:    cfg_r.output_gain     <= pwdata[ldadsr_pkg::GAIN_W-1:0];
        ldadsr_pkg::REG_LOOP:    cfg_r.loop_enable     <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      ldadsr_pkg::REG_DELAY:   prdata = ldadsr_pkg::DATA_W'(cfg_r.delay_samples);
      ldadsr_pkg::REG_ATTACK:  prdata = ldadsr_pkg::DATA_W'(cfg_r.attack_samples);
      ldadsr_pkg::REG_DECAY:   prdata = ldadsr_pkg::DATA_W'(cfg_r.decay_samples);
      ldadsr_pkg::REG_RELEASE: prdata = ldadsr_pkg::DATA_W'(cfg_r.release_samples);
      ldadsr_pkg::REG_SUSTAIN: prdata = ldadsr_pkg::DATA_W'(cfg_r.sustain_level);
      ldadsr_pkg::REG_GAIN:    prdata = ldadsr_pkg::DATA_W'(cfg_r.output_gain);
      ldadsr_pkg::REG_LOOP:    prdata = ldadsr_pkg::DATA_W'(cfg_r.loop_enable);
      default:                 prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ hdl/ldadsr_div.sv @@
// ----------------------------------------------------------------------------
// ldadsr_div - bit-serial restoring divider
// One quotient bit per cycle; a zero divisor is treated as one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ldadsr_div #(
  parameter int DVD_W = 24,
  parameter int DVS_W = 24
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output logic                  busy,
  output logic                  done,
  output logic      [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] quo_r, quo_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVS_W-1:0] dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r;
  logic [DVS_W:0]   trial;
  logic             q_bit;

  // quo_r shifts dividend bits out at the top and quotient bits in at the bottom
  always_comb begin
    trial = {rem_r, quo_r[DVD_W-1]};
    q_bit = (trial >= {1'b0, dvs_r});
    if (q_bit) begin
      rem_nxt = DVS_W'(trial - {1'b0, dvs_r});
    end else begin
      rem_nxt = trial[DVS_W-1:0];
    end
    quo_nxt = {quo_r[DVD_W-2:0], q_bit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= (divisor == '0) ? DVS_W'(1) : divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

@@ hdl/ldadsr_seq.sv @@
// ----------------------------------------------------------------------------
// ldadsr_seq - envelope sequencer and state
// Takes one gate item, handles gate edges, drives the shared divider for the
// ramp or release step, advances the stage and scales the level by the gain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ldadsr_seq #(
  parameter int FRAC_BITS  = ldadsr_pkg::FRAC_BITS_DEF,
  parameter int COUNT_BITS = ldadsr_pkg::COUNT_BITS_DEF,
  parameter int LW         = FRAC_BITS + 1
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire ldadsr_pkg::cfg_t             cfg,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic                         in_gate,
  output logic                              div_start,
  output logic [LW-1:0]                     div_dividend,
  output logic [ldadsr_pkg::CFG_W-1:0]      div_divisor,
  input  wire logic                         div_done,
  input  wire logic [LW-1:0]                div_quo,
  output logic                              res_valid,
  output ldadsr_pkg::res_t                  res,
  input  wire logic                         res_take
);

  localparam int             PW      = LW + ldadsr_pkg::GAIN_W;
  localparam int             SW      = (LW > ldadsr_pkg::CFG_W) ? LW : ldadsr_pkg::CFG_W;
  localparam int             DW      = (COUNT_BITS > ldadsr_pkg::CFG_W) ?
                                       COUNT_BITS : ldadsr_pkg::CFG_W;
  localparam logic [LW-1:0]  LVL_ONE = LW'(1) << FRAC_BITS;
  localparam logic [LW-1:0]  LVL_EPS = LW'((64'd1 << FRAC_BITS) / 64'd1000000);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  ldadsr_pkg::seq_state_t state_r, state_nxt;
  ldadsr_pkg::stage_t     stage_r, stage_nxt, p1_stage;
  logic                   prev_r, prev_nxt;
  logic                   fall_r, fall_nxt;
  logic [LW-1:0]          level_r, level_nxt, p1_level;
  logic [LW-1:0]          rstep_r, rstep_nxt;
  logic [COUNT_BITS-1:0]  dcnt_r, dcnt_nxt, p1_dcnt, dcnt_inc;
  logic [PW-1:0]          prod_r, prod_nxt;

  logic                   rise, fall, att_jump;
  logic [SW-1:0]          sus_w;
  logic [LW-1:0]          sus_eff, step, rs;
  logic [LW:0]            sum_att, sum_dec;

  assign sus_w    = SW'(cfg.sustain_level);
  assign sus_eff  = (sus_w > SW'(LVL_ONE)) ? LVL_ONE : LW'(sus_w);
  assign att_jump = (cfg.attack_samples <= ldadsr_pkg::CFG_W'(1));
  assign rise     = ~prev_r & in_gate;
  assign fall     = prev_r & ~in_gate;

  // Gate edge handling, ahead of the per-stage update
  always_comb begin
    p1_stage = stage_r;
    p1_level = level_r;
    p1_dcnt  = dcnt_r;
    if (rise) begin
      if (cfg.delay_samples == '0) begin
        if (att_jump) begin
          p1_stage = ldadsr_pkg::ST_DECAY;
          p1_level = LVL_ONE;
        end else begin
          p1_stage = ldadsr_pkg::ST_ATTACK;
        end
      end else begin
        if (level_r <= LVL_EPS) begin
          p1_level = '0;
          p1_dcnt  = '0;
        end
        p1_stage = ldadsr_pkg::ST_DELAY;
      end
    end else if (fall) begin
      p1_stage = ldadsr_pkg::ST_RELEASE;
    end
  end

  assign step     = (div_quo == '0) ? LW'(1) : div_quo;
  assign rs       = fall_r ? step : rstep_r;
  assign sum_att  = {1'b0, level_r} + {1'b0, step};
  assign sum_dec  = {1'b0, sus_eff} + {1'b0, step};
  assign dcnt_inc = (dcnt_r != CNT_MAX) ? dcnt_r + 1'b1 : dcnt_r;

  always_comb begin
    state_nxt    = state_r;
    stage_nxt    = stage_r;
    prev_nxt     = prev_r;
    fall_nxt     = fall_r;
    level_nxt    = level_r;
    rstep_nxt    = rstep_r;
    dcnt_nxt     = dcnt_r;
    prod_nxt     = prod_r;
    in_ready     = 1'b0;
    res_valid    = 1'b0;
    div_start    = 1'b0;
    div_dividend = LVL_ONE;
    div_divisor  = cfg.attack_samples;

    // one division per item: release step on a falling gate, else the ramp step
    if (fall) begin
      div_dividend = level_r;
      div_divisor  = cfg.release_samples;
    end else if (p1_stage == ldadsr_pkg::ST_DECAY) begin
      div_dividend = LVL_ONE - sus_eff;
      div_divisor  = cfg.decay_samples;
    end

    unique case (state_r)
      ldadsr_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          prev_nxt  = in_gate;
          fall_nxt  = fall;
          stage_nxt = p1_stage;
          level_nxt = p1_level;
          dcnt_nxt  = p1_dcnt;
          div_start = 1'b1;
          state_nxt = ldadsr_pkg::S_DIV;
        end
      end
      ldadsr_pkg::S_DIV: begin
        if (div_done) begin
          if (fall_r) begin
            rstep_nxt = step;
          end
          case (stage_r)
            ldadsr_pkg::ST_DELAY: begin
              if (DW'(dcnt_inc) >= DW'(cfg.delay_samples)) begin
                dcnt_nxt = '0;
                if (att_jump) begin
                  stage_nxt = ldadsr_pkg::ST_DECAY;
                  level_nxt = LVL_ONE;
                end else begin
                  stage_nxt = ldadsr_pkg::ST_ATTACK;
                end
              end else begin
                dcnt_nxt = dcnt_inc;
              end
            end
            ldadsr_pkg::ST_ATTACK: begin
              if (sum_att >= {1'b0, LVL_ONE}) begin
                level_nxt = LVL_ONE;
                stage_nxt = ldadsr_pkg::ST_DECAY;
              end else begin
                level_nxt = sum_att[LW-1:0];
              end
            end
            ldadsr_pkg::ST_DECAY: begin
              // may raise the level when sustain sits above it
              if ({1'b0, level_r} <= sum_dec) begin
                level_nxt = sus_eff;
                stage_nxt = ldadsr_pkg::ST_SUSTAIN;
              end else begin
                level_nxt = level_r - step;
              end
            end
            ldadsr_pkg::ST_SUSTAIN: begin
              if (cfg.loop_enable) begin
                stage_nxt = ldadsr_pkg::ST_ATTACK;
              end
              level_nxt = sus_eff;
            end
            ldadsr_pkg::ST_RELEASE: begin
              if (level_r <= rs) begin
                level_nxt = '0;
                stage_nxt = ldadsr_pkg::ST_OFF;
                dcnt_nxt  = '0;
              end else begin
                level_nxt = level_r - rs;
              end
            end
            default: ;
          endcase
          state_nxt = ldadsr_pkg::S_MUL;
        end
      end
      ldadsr_pkg::S_MUL: begin
        prod_nxt  = PW'(level_r) * PW'(cfg.output_gain);
        state_nxt = ldadsr_pkg::S_DONE;
      end
      ldadsr_pkg::S_DONE: begin
        res_valid = 1'b1;
        if (res_take) begin
          state_nxt = ldadsr_pkg::S_IDLE;
        end
      end
      default: state_nxt = ldadsr_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ldadsr_pkg::S_IDLE;
      stage_r <= ldadsr_pkg::ST_OFF;
      prev_r  <= 1'b0;
      fall_r  <= 1'b0;
      level_r <= '0;
      rstep_r <= '0;
      dcnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      stage_r <= stage_nxt;
      prev_r  <= prev_nxt;
      fall_r  <= fall_nxt;
      level_r <= level_nxt;
      rstep_r <= rstep_nxt;
      dcnt_r  <= dcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  assign res.envelope = prod_r[FRAC_BITS +: ldadsr_pkg::OUT_W];
  assign res.stage    = stage_r;

endmodule

`default_nettype wire

@@ hdl/linear_dadsr_envelope.sv @@
// Each accepted item runs through the bit-serial step divider (S_DIV, one quotient bit
// per cycle), the gain multiply (S_MUL) and S_DONE, where it waits for the output
// register; no new item is taken until the sequencer is back in S_IDLE.
// in_ready drops for the whole item; the output register still holds a finished
// result while the next item is taken.
// Reset (rst_n low, synchronous): stage off, level zero, gain 32768, others zero.
// ----------------------------------------------------------------------------
// linear_dadsr_envelope - linear DADSR envelope generator
// Per-sample gate in, scaled envelope level and stage out; APB-style setup.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module linear_dadsr_envelope #(
  parameter int FRAC_BITS  = ldadsr_pkg::FRAC_BITS_DEF,
  parameter int COUNT_BITS = ldadsr_pkg::COUNT_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [ldadsr_pkg::ADDR_W-1:0] paddr,
  input  wire logic [ldadsr_pkg::DATA_W-1:0] pwdata,
  output logic      [ldadsr_pkg::DATA_W-1:0] prdata,
  output logic                               pready,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_gate,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [ldadsr_pkg::OUT_W-1:0]  out_envelope_out,
  output logic      [2:0]                    out_stage_now
);

  localparam int LW = FRAC_BITS + 1;

  ldadsr_pkg::cfg_t                 cfg;
  ldadsr_pkg::res_t                 res;
  logic                             res_valid, res_take;
  logic                             div_start, div_busy, div_done;
  logic [LW-1:0]                    div_dividend, div_quo;
  logic [ldadsr_pkg::CFG_W-1:0]     div_divisor;

  logic                             out_valid_r;
  logic [ldadsr_pkg::OUT_W-1:0]     out_env_r;
  ldadsr_pkg::stage_t               out_stage_r;

  ldadsr_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ldadsr_div #(
    .DVD_W (LW),
    .DVS_W (ldadsr_pkg::CFG_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quo)
  );

  ldadsr_seq #(
    .FRAC_BITS  (FRAC_BITS),
    .COUNT_BITS (COUNT_BITS),
    .LW         (LW)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_gate      (in_gate),
    .div_start    (div_start),
    .div_dividend (div_dividend),
    .div_divisor  (div_divisor),
    .div_done     (div_done),
    .div_quo      (div_quo),
    .res_valid    (res_valid),
    .res          (res),
    .res_take     (res_take)
  );

  // output register: loads when empty or emptying this cycle
  assign res_take = res_valid & (~out_valid_r | out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_env_r   <= res.envelope;
      out_stage_r <= res.stage;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_envelope_out = out_env_r;
  assign out_stage_now    = out_stage_r;

  a_start_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> (in_valid && in_ready))
    else $error("divider started without an accepted item");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> div_busy)
    else $error("divider idle after item accepted");

  a_done_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> !in_ready)
    else $error("divider finished while sequencer idle");

  a_off_is_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stage_now == ldadsr_pkg::ST_OFF) |-> (out_envelope_out == '0))
    else $error("non-zero envelope in off stage");

endmodule

`default_nettype wire

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb - self-checking bench for the linear DADSR envelope
// Streams gate ticks through the valid/ready input, predicts each envelope
// result in the bench or takes it from a table row, and compares it with the
// output channel. A short directed table comes first, then random phases of
// register settings and note patterns, with random idle gaps on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import ldadsr_pkg::*;

  localparam int          RANDOM_ITEMS = 950;
  localparam logic [63:0] LVL_FULL     = 64'd1 << FRAC_BITS_DEF;
  localparam logic [63:0] LVL_EPS      = LVL_FULL / 1000000;
  localparam logic [23:0] CNT_TOP      = '1;

  // byte addresses, four bytes per register
  localparam logic [4:0] A_DELAY   = {REG_DELAY, 2'b00};
  localparam logic [4:0] A_ATTACK  = {REG_ATTACK, 2'b00};
  localparam logic [4:0] A_DECAY   = {REG_DECAY, 2'b00};
  localparam logic [4:0] A_RELEASE = {REG_RELEASE, 2'b00};
  localparam logic [4:0] A_SUSTAIN = {REG_SUSTAIN, 2'b00};
  localparam logic [4:0] A_GAIN    = {REG_GAIN, 2'b00};
  localparam logic [4:0] A_LOOP    = {REG_LOOP, 2'b00};
  localparam logic [4:0] A_SPARE   = 5'd28;   // no register behind it

  localparam int PLAN_LEN = 44;

  typedef struct packed {
    logic        is_write;
    logic [4:0]  addr;
    logic [31:0] data;
    logic        gate;
    logic        typed;
    logic [15:0] env;
    stage_t      stage;
  } step_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        psel, penable, pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid, in_ready, in_gate;
  logic        out_valid, out_ready;
  logic [15:0] out_envelope_out;
  logic [2:0]  out_stage_now;

  // bench copy of the registers and the envelope state
  logic [23:0] cfg_delay   = '0;
  logic [23:0] cfg_attack  = '0;
  logic [23:0] cfg_decay   = '0;
  logic [23:0] cfg_release = '0;
  logic [23:0] cfg_sustain = '0;
  logic [15:0] cfg_gain    = GAIN_RESET;
  logic        cfg_loop    = 1'b0;
  logic        gate_q      = 1'b0;
  logic [23:0] level       = '0;
  logic [23:0] rel_step    = '0;
  logic [23:0] dly_cnt     = '0;
  stage_t      stage_q     = ST_OFF;

  res_t        env_expected[$];
  res_t        want;
  int unsigned err_count  = 0;
  int unsigned items_sent = 0;
  bit          calm_in    = 1'b0;
  step_row_t   plan [PLAN_LEN];

  linear_dadsr_envelope i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_gate          (in_gate),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_envelope_out (out_envelope_out),
    .out_stage_now    (out_stage_now)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void report_miss(string msg);
    err_count++;
    if (err_count <= 10) $display("%s", msg);
  endfunction

  function automatic logic [63:0] ramp_step(logic [63:0] num, logic [63:0] len);
    logic [63:0] q;
    q = num / ((len == 0) ? 64'd1 : len);
    return (q == 0) ? 64'd1 : q;
  endfunction

  function automatic void apply_reg(logic [4:0] addr, logic [31:0] data);
    case (reg_idx_t'(addr[4:2]))
      REG_DELAY:   cfg_delay   = data[23:0];
      REG_ATTACK:  cfg_attack  = data[23:0];
      REG_DECAY:   cfg_decay   = data[23:0];
      REG_RELEASE: cfg_release = data[23:0];
      REG_SUSTAIN: cfg_sustain = data[23:0];
      REG_GAIN:    cfg_gain    = data[15:0];
      REG_LOOP:    cfg_loop    = data[0];
      default: ;
    endcase
  endfunction

  // Advance the envelope by one sample tick and return the scaled output
  function automatic res_t advance_envelope(logic gate);
    logic [63:0] sus, d, acc, lvl;
    res_t        r;
    sus = (cfg_sustain > LVL_FULL) ? LVL_FULL : 64'(cfg_sustain);
    if (!gate_q && gate) begin
      if (cfg_delay == 0) begin
        if (cfg_attack <= 1) begin
          stage_q = ST_DECAY;
          level   = LVL_FULL[23:0];
        end else begin
          stage_q = ST_ATTACK;
        end
      end else begin
        // a near-silent retrigger restarts the delay from scratch
        if (level <= LVL_EPS) begin
          level   = '0;
          dly_cnt = '0;
        end
        stage_q = ST_DELAY;
      end
    end else if (gate_q && !gate) begin
      stage_q  = ST_RELEASE;
      acc      = ramp_step(level, cfg_release);
      rel_step = acc[23:0];
    end
    gate_q = gate;

    case (stage_q)
      ST_DELAY: begin
        if (dly_cnt < CNT_TOP) dly_cnt++;
        if (dly_cnt >= cfg_delay) begin
          dly_cnt = '0;
          if (cfg_attack <= 1) begin
            stage_q = ST_DECAY;
            level   = LVL_FULL[23:0];
          end else begin
            stage_q = ST_ATTACK;
          end
        end
      end
      ST_ATTACK: begin
        acc = level + ramp_step(LVL_FULL, cfg_attack);
        if (acc >= LVL_FULL) begin
          level   = LVL_FULL[23:0];
          stage_q = ST_DECAY;
        end else begin
          level = acc[23:0];
        end
      end
      ST_DECAY: begin
        d = ramp_step(LVL_FULL - sus, cfg_decay);
        // may lift the level up to sustain
        if (level <= sus + d) begin
          level   = sus[23:0];
          stage_q = ST_SUSTAIN;
        end else begin
          acc   = level - d;
          level = acc[23:0];
        end
      end
      ST_SUSTAIN: begin
        if (cfg_loop) stage_q = ST_ATTACK;
        level = sus[23:0];
      end
      ST_RELEASE: begin
        if (level <= rel_step) begin
          level   = '0;
          stage_q = ST_OFF;
          dly_cnt = '0;
        end else begin
          level = level - rel_step;
        end
      end
      default: ;
    endcase

    lvl        = (level > LVL_FULL) ? LVL_FULL : 64'(level);
    acc        = (lvl * cfg_gain) >> FRAC_BITS_DEF;
    r.envelope = acc[15:0];
    r.stage    = stage_q;
    return r;
  endfunction

  function automatic logic [31:0] pick_len(bit wide);
    if (wide) return $urandom();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1);
    return $urandom_range(2, 12);
  endfunction

  task automatic cfg_write(input logic [4:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    apply_reg(addr, data);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_gate(input logic gate, input logic typed, input logic [15:0] env,
                           input stage_t stage);
    int   gap;
    res_t guess;
    gap = calm_in ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_gate  <= gate;
    do @(posedge clk); while (!in_ready);
    guess = advance_envelope(gate);
    if (typed) begin
      guess.envelope = env;
      guess.stage    = stage;
    end
    env_expected.push_back(guess);
    items_sent++;
  endtask

  // stop feeding and wait until every item has come back
  task automatic finish_items();
    in_valid <= 1'b0;
    while (env_expected.size() != 0) @(posedge clk);
  endtask

  initial begin
    int   k, n, run_left;
    logic gate_lvl, g;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= '0;
    pwdata    <= '0;
    in_valid  <= 1'b0;
    in_gate   <= 1'b0;
    rst_n     <= 1'b0;
    plan = '{
      '{1'b0, 5'd0,      32'd0,         1'b0, 1'b1, 16'd0,     ST_OFF},
      '{1'b0, 5'd0,      32'd0,         1'b1, 1'b1, 16'd0,     ST_SUSTAIN},
      '{1'b0, 5'd0,      32'd0,         1'b0, 1'b1, 16'd0,     ST_OFF},
      '{1'b1, A_SUSTAIN, 32'h0080_0000, 1'b0, 1'b0, 16'd0,     ST_OFF},
      '{1'b1, A_GAIN,    32'h0000_FFFF, 1'b0, 1'b0, 16'd0,     ST_OFF},
      '{1'b0, 5'd0,      32'd0,         1'b1, 1'b1, 16'hFFFF,  ST_SUSTAIN},
      '{1'b0, 5'd0,      32'd0,         1'b1, 1'b1, 16'hFFFF,  ST_SUSTAIN},
      '{1'b1, A_LOOP,    32'd1,         1'b0, 1'b0, 16'd0,     ST_OFF},
      '{1'b0, 5'd0,      32'd0,         1'b1, 1'b1, 16'hFFFF,  ST_ATTACK},
      '{1'b0, 5'd0,      32'd0,         1'b0, 1'b1, 16'd0,     ST_OFF},
      '{1'b1, A_SUSTAIN, 32'h00FF_FFFF, 1'b0, 1'b0, 16'd0,     ST_OFF},
      '{1'b1, A_LOOP,    32'd0,         1'b0, 1'b0, 16'd0,     ST_OFF},
      '{1'b1, A_GAIN,    32'd0,         1'b0, 1'b0, 16'd0,     ST_OFF},
      '{1'b0, 5'd0,      32'd0,         1'b1, 1'b1, 16'd0,     ST_SUSTAIN},
      '{1'b0, 5'd0,      32'd0,         1'b0, 1'b1, 16'd0,     ST_OFF},
      '{1'b1, A_GAIN,    32'h0000_8000, 1'b0, 1'b0, 16'd0,     ST_OFF},
      '{1'b1, A_DELAY,   32'd3,         1'b0, 1'b0, 16'd0,     ST_OFF},
      '{1'b1, A_ATTACK,  32'd4,         1'b0, 1'b0, 16'd0,     ST_OFF},
      '{1'b1, A_DECAY,   32'd2,         1'b0, 1'b0, 16'd0,     ST_OFF},
      '{1'b1, A_RELEASE, 32'd3,         1'b0, 1'b0, 16'd0,     ST_OFF},
      '{1'b1, A_SUSTAIN, 32'h0040_0000, 1'b0, 1'b0, 16'd0,     ST_OFF},
      // one full note: delay, attack, decay, sustain, then release to off
      '{1'b0, 5'd0,      32'd0,         1'b1, 1'b0, 16'd0,     ST_OFF},
      '{1'b0, 5'd0,      32'd0,         1'b1, 1'b0, 16'd0,     ST_OFF},
      '{1'b0, 5'd0,      32'd0,         1'b1, 1'b0, 16'd0,     ST_OFF},
      '{1'b0, 5'd0,      32'd0,         1'b1, 1'b0, 16'd0,     ST_OFF},
      '{1'b0, 5'd0,      32'd0,         1'b1, 1'b0, 16'd0,     ST_OFF},
      '{1'b0, 5'd0,      32'd0,         1'b1, 1'b0, 16'd0,     ST_OFF},
      '{1'b0, 5'd0,      32'd0,         1'b1, 1'b0, 16'd0,     ST_OFF},
      '{1'b0, 5'd0,      32'd0,         1'b1, 1'b0, 16'd0,     ST_OFF},
      '{1'b0, 5'd0,      32'd0,         1'b1, 1'b0, 16'd0,     ST_OFF},
      '{1'b0, 5'd0,      32'd0,         1'b0, 1'b0, 16'd0,     ST_OFF},
      '{1'b0, 5'd0,      32'd0,         1'b0, 1'b0, 16'd0,     ST_OFF},
      '{1'b0, 5'd0,      32'd0,         1'b0, 1'b0, 16'd0,     ST_OFF},
      '{1'b0, 5'd0,      32'd0,         1'b0, 1'b0, 16'd0,     ST_OFF},
      '{1'b1, A_DELAY,   32'h00FF_FFFF, 1'b0, 1'b0, 16'd0,     ST_OFF},
      '{1'b1, A_ATTACK,  32'h00FF_FFFF, 1'b0, 1'b0, 16'd0,     ST_OFF},
      '{1'b1, A_DECAY,   32'h00FF_FFFF, 1'b0, 1'b0, 16'd0,     ST_OFF},
      '{1'b1, A_RELEASE, 32'h00FF_FFFF, 1'b0, 1'b0, 16'd0,     ST_OFF},
      '{1'b1, A_SPARE,   32'hFFFF_FFFF, 1'b0, 1'b0, 16'd0,     ST_OFF},
      '{1'b0, 5'd0,      32'd0,         1'b1, 1'b0, 16'd0,     ST_OFF},
      '{1'b0, 5'd0,      32'd0,         1'b0, 1'b0, 16'd0,     ST_OFF},
      '{1'b1, A_DELAY,   32'd0,         1'b0, 1'b0, 16'd0,     ST_OFF},
      '{1'b0, 5'd0,      32'd0,         1'b1, 1'b0, 16'd0,     ST_OFF},
      '{1'b0, 5'd0,      32'd0,         1'b0, 1'b0, 16'd0,     ST_OFF}
    };
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    for (k = 0; k < PLAN_LEN; k++) begin
      if (plan[k].is_write) begin
        finish_items();
        cfg_write(plan[k].addr, plan[k].data);
      end else begin
        send_gate(plan[k].gate, plan[k].typed, plan[k].env, plan[k].stage);
      end
    end

    // random phases: new settings, then a run of note patterns with some noise
    items_sent = 0;
    gate_lvl   = 1'b0;
    run_left   = 0;
    while (items_sent < RANDOM_ITEMS) begin
      finish_items();
      cfg_write(A_DELAY, ($urandom_range(0, 2) == 0) ? 32'd0
                                                     : pick_len($urandom_range(0, 7) == 0));
      cfg_write(A_ATTACK, pick_len($urandom_range(0, 7) == 0));
      cfg_write(A_DECAY, pick_len($urandom_range(0, 7) == 0));
      cfg_write(A_RELEASE, pick_len($urandom_range(0, 7) == 0));
      case ($urandom_range(0, 3))
        0: cfg_write(A_SUSTAIN, 32'd0);
        1: cfg_write(A_SUSTAIN, LVL_FULL[31:0]);
        2: cfg_write(A_SUSTAIN, $urandom_range(0, LVL_FULL[31:0]));
        default: cfg_write(A_SUSTAIN, $urandom());
      endcase
      cfg_write(A_GAIN, $urandom());
      cfg_write(A_LOOP, ($urandom_range(0, 4) == 0) ? $urandom() : $urandom_range(0, 1));
      if ($urandom_range(0, 3) == 0) cfg_write(A_SPARE, $urandom());
      calm_in = ($urandom_range(0, 3) == 0);
      n = $urandom_range(15, 45);
      repeat (n) begin
        if ($urandom_range(0, 5) == 0) begin
          g = $urandom_range(0, 1);
        end else begin
          if (run_left == 0) begin
            gate_lvl = !gate_lvl;
            run_left = gate_lvl ? $urandom_range(1, 25) : $urandom_range(1, 12);
          end
          run_left--;
          g = gate_lvl;
        end
        send_gate(g, 1'b0, 16'd0, ST_OFF);
      end
    end

    finish_items();
    repeat (FRAC_BITS_DEF + 8) @(posedge clk);
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // result side: random stall before each item, with calm stretches
  initial begin
    int stall;
    bit calm_out;
    calm_out = 1'b0;
    out_ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if ($urandom_range(0, 29) == 0) calm_out = !calm_out;
      stall = calm_out ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (env_expected.size() == 0) begin
        report_miss($sformatf("unexpected item: envelope %0d stage %0d",
                              out_envelope_out, out_stage_now));
      end else begin
        want = env_expected.pop_front();
        if (out_envelope_out !== want.envelope || out_stage_now !== want.stage) begin
          report_miss($sformatf("mismatch: envelope %0d stage %0d, expected %0d stage %0d",
                                out_envelope_out, out_stage_now, want.envelope,
                                want.stage));
        end
      end
    end
  end

  initial begin
    #8_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
